// ===== src/arp_resp_pkg.sv =====
// Package for the ARP responder: payload types, frame constants and reply byte builder.
package arp_resp_pkg;

  localparam int unsigned FrameLen  = 42;
  localparam int unsigned PosWidth  = 6;
  localparam int unsigned MacWidth  = 48;
  localparam int unsigned IpWidth   = 32;
  localparam int unsigned CfgWidth  = 48;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned FrameBits = FrameLen * 8;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgEnable = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgOwnMac = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgOwnIp  = 2'd2;

  // Byte positions in the received frame
  localparam logic [PosWidth-1:0] PosEtypeHi  = 6'd12;
  localparam logic [PosWidth-1:0] PosEtypeLo  = 6'd13;
  localparam logic [PosWidth-1:0] PosOperHi   = 6'd20;
  localparam logic [PosWidth-1:0] PosOperLo   = 6'd21;
  localparam logic [PosWidth-1:0] PosSndMac   = 6'd22;
  localparam logic [PosWidth-1:0] PosSndIp    = 6'd28;
  localparam logic [PosWidth-1:0] PosSndIpEnd = 6'd32;
  localparam logic [PosWidth-1:0] PosTgtIp    = 6'd38;
  localparam logic [PosWidth-1:0] PosFull     = PosWidth'(FrameLen);
  localparam logic [PosWidth-1:0] PosFinal    = PosWidth'(FrameLen - 1);

  localparam logic [7:0] EtypeArpHi = 8'h08;
  localparam logic [7:0] EtypeArpLo = 8'h06;
  localparam logic [7:0] OperReqHi  = 8'h00;
  localparam logic [7:0] OperReqLo  = 8'h01;

  // EtherType, hardware type, protocol type, sizes and reply opcode
  localparam logic [79:0] ReplyFixed = 80'h0806_0001_0800_0604_0002;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_last;
  } rx_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_last;
  } tx_item_t;

  function automatic logic [7:0] reply_byte(
    input logic [PosWidth-1:0] k,
    input logic [MacWidth-1:0] req_mac,
    input logic [IpWidth-1:0]  req_ip,
    input logic [MacWidth-1:0] own_mac,
    input logic [IpWidth-1:0]  own_ip
  );
    logic [FrameBits-1:0] frm;
    logic [PosWidth-1:0]  rev;
    frm = {req_mac, own_mac, ReplyFixed, own_mac, own_ip, req_mac, req_ip};
    rev = PosFinal - k;
    return frm[rev*8 +: 8];
  endfunction

endpackage

// ===== src/arp_request_responder.sv =====
// ARP request responder: parses received frames and streams out ARP replies.
//
// Received bytes are taken one per clock while rx_stall_o is low. Each byte
// updates the frame checks and the captured sender addresses in the cycle it
// is accepted; on the last byte of a qualifying request a 42-byte reply starts
// on the transmit side in the next cycle and leaves at one byte per clock while
// tx_stall_i stays low. The transmit side holds its own copy of the sender
// addresses, so the next frame streams in while the reply drains. rx_stall_o
// rises only when a frame has reached its 42nd byte while the previous reply
// has not yet handed over its final byte; with an unstalled transmit side
// frames of 42 bytes or more arrive back to back with no wait.
module arp_request_responder (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  rx_valid_i,
  output logic                                  rx_stall_o,
  input  arp_resp_pkg::rx_item_t                rx_data_i,
  output logic                                  tx_valid_o,
  input  logic                                  tx_stall_i,
  output arp_resp_pkg::tx_item_t                tx_data_o,
  input  logic                                  cfg_we_i,
  input  logic [arp_resp_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [arp_resp_pkg::CfgWidth-1:0]     cfg_wdata_i
);

  logic                                enable_q;
  logic [arp_resp_pkg::MacWidth-1:0]   own_mac_q;
  logic [arp_resp_pkg::IpWidth-1:0]    own_ip_q;

  logic [arp_resp_pkg::PosWidth-1:0]   pos_q, pos_d;
  logic                                checks_q, checks_d;
  logic [arp_resp_pkg::MacWidth-1:0]   rmac_q, rmac_d;
  logic [arp_resp_pkg::IpWidth-1:0]    rip_q, rip_d;

  logic                                tx_valid_q, tx_valid_d;
  logic [arp_resp_pkg::PosWidth-1:0]   idx_q, idx_d;
  logic [arp_resp_pkg::MacWidth-1:0]   tx_mac_q, tx_mac_d;
  logic [arp_resp_pkg::IpWidth-1:0]    tx_ip_q, tx_ip_d;

  logic                                rx_acc;
  logic                                tx_acc;
  logic                                tx_done;
  logic                                tx_free;
  logic                                fire;
  logic [arp_resp_pkg::PosWidth-1:0]   ip_off;
  logic [7:0]                          own_ip_byte;
  logic [7:0]                          b;

  assign tx_acc  = tx_valid_q && !tx_stall_i;
  assign tx_done = tx_acc && (idx_q == arp_resp_pkg::PosFinal);
  assign tx_free = !tx_valid_q || tx_done;

  // Hold input once a reply could be due and the transmitter is still busy
  assign rx_stall_o = (pos_q >= arp_resp_pkg::PosFinal) && !tx_free;
  assign rx_acc     = rx_valid_i && !rx_stall_o;

  assign b           = rx_data_i.rx_byte;
  assign ip_off      = pos_q - arp_resp_pkg::PosTgtIp;
  assign own_ip_byte = own_ip_q[(2'd3 - ip_off[1:0])*8 +: 8];

  always_comb begin
    pos_d    = pos_q;
    checks_d = checks_q;
    rmac_d   = rmac_q;
    rip_d    = rip_q;
    fire     = 1'b0;
    if (rx_acc) begin
      if (pos_q < arp_resp_pkg::PosFull) begin
        if (pos_q == arp_resp_pkg::PosEtypeHi && b != arp_resp_pkg::EtypeArpHi) checks_d = 1'b0;
        if (pos_q == arp_resp_pkg::PosEtypeLo && b != arp_resp_pkg::EtypeArpLo) checks_d = 1'b0;
        if (pos_q == arp_resp_pkg::PosOperHi && b != arp_resp_pkg::OperReqHi) checks_d = 1'b0;
        if (pos_q == arp_resp_pkg::PosOperLo && b != arp_resp_pkg::OperReqLo) checks_d = 1'b0;
        if (pos_q >= arp_resp_pkg::PosSndMac && pos_q < arp_resp_pkg::PosSndIp) begin
          rmac_d = {rmac_q[arp_resp_pkg::MacWidth-9:0], b};
        end
        if (pos_q >= arp_resp_pkg::PosSndIp && pos_q < arp_resp_pkg::PosSndIpEnd) begin
          rip_d = {rip_q[arp_resp_pkg::IpWidth-9:0], b};
        end
        if (pos_q >= arp_resp_pkg::PosTgtIp && b != own_ip_byte) checks_d = 1'b0;
        pos_d = pos_q + 6'd1;
      end
      if (rx_data_i.rx_last) begin
        fire     = enable_q && checks_d && (pos_d >= arp_resp_pkg::PosFull);
        pos_d    = '0;
        checks_d = 1'b1;
      end
    end
  end

  always_comb begin
    tx_valid_d = tx_valid_q;
    idx_d      = idx_q;
    tx_mac_d   = tx_mac_q;
    tx_ip_d    = tx_ip_q;
    if (fire) begin
      // Start a new reply; transmitter is free whenever this can happen
      tx_valid_d = 1'b1;
      idx_d      = '0;
      tx_mac_d   = rmac_d;
      tx_ip_d    = rip_d;
    end else if (tx_done) begin
      tx_valid_d = 1'b0;
    end else if (tx_acc) begin
      idx_d = idx_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b0;
      own_mac_q  <= '0;
      own_ip_q   <= '0;
      pos_q      <= '0;
      checks_q   <= 1'b1;
      tx_valid_q <= 1'b0;
      idx_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          arp_resp_pkg::CfgEnable: enable_q  <= cfg_wdata_i[0];
          arp_resp_pkg::CfgOwnMac: own_mac_q <= cfg_wdata_i[arp_resp_pkg::MacWidth-1:0];
          arp_resp_pkg::CfgOwnIp:  own_ip_q  <= cfg_wdata_i[arp_resp_pkg::IpWidth-1:0];
          default: ;
        endcase
      end
      pos_q      <= pos_d;
      checks_q   <= checks_d;
      tx_valid_q <= tx_valid_d;
      idx_q      <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rmac_q   <= rmac_d;
    rip_q    <= rip_d;
    tx_mac_q <= tx_mac_d;
    tx_ip_q  <= tx_ip_d;
  end

  assign tx_valid_o        = tx_valid_q;
  assign tx_data_o.tx_byte = arp_resp_pkg::reply_byte(idx_q, tx_mac_q, tx_ip_q,
                                                      own_mac_q, own_ip_q);
  assign tx_data_o.tx_last = (idx_q == arp_resp_pkg::PosFinal);

endmodule

// ===== src/arp_resp_chk.sv =====
// Port-level checker for the ARP responder, bound to the top level.
module arp_resp_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              rx_valid_i,
  input logic                              rx_stall_o,
  input arp_resp_pkg::rx_item_t            rx_data_i,
  input logic                              tx_valid_o,
  input logic                              tx_stall_i,
  input arp_resp_pkg::tx_item_t            tx_data_o,
  input logic                              cfg_we_i,
  input logic [arp_resp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input logic [arp_resp_pkg::CfgWidth-1:0] cfg_wdata_i
);

  // Hold a stalled reply byte
  a_tx_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_valid_o && tx_stall_i |=> tx_valid_o && $stable(tx_data_o))
    else $error("stalled reply transaction changed");

  // Reply bytes run without gaps until the final one
  a_tx_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_valid_o && !tx_stall_i && !tx_data_o.tx_last |=> tx_valid_o)
    else $error("reply broken before its final byte");

  // A reply starts only after the last byte of a frame was taken
  a_tx_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(tx_valid_o) |-> $past(rx_valid_i && !rx_stall_o && rx_data_i.rx_last))
    else $error("reply started without a completed frame");

  // Input is held back only while a reply is in flight
  a_rx_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_stall_o |-> tx_valid_o)
    else $error("input stalled with no reply pending");

endmodule

bind arp_request_responder arp_resp_chk u_arp_resp_chk (.*);
